/* hdl/event_trace_ring_buffer_core_defines.svh */
// ----------------------------------------------------------------------------
// event trace ring buffer assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef EVENT_TRACE_RING_BUFFER_CORE_DEFINES_SVH
`define EVENT_TRACE_RING_BUFFER_CORE_DEFINES_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define ETRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define ETRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ETRB_ASSERT(label, prop, msg)
`define ETRB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/etrb_pkg.sv */
// ----------------------------------------------------------------------------
// etrb_pkg
// shared widths, codes and result type of the event trace ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package etrb_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CPU_W      = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MAXE_W     = 7;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned FILL_W     = 11;
  localparam int unsigned ENTRY_W    = KIND_W + TIME_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 144;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_RESET  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RECORDED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_REFUSED  = 3'd5,
    ST_CLEARED  = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACE_ENABLE = 2'd0,
    CFG_RING_SIZE    = 2'd1
  } cfg_reg_e;

  localparam logic [KIND_W-1:0] KIND_SWITCH_IN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SWITCH_OUT = 3'd1;

  typedef struct packed {
    status_e             status;
    logic [KIND_W-1:0]   entry_kind;
    logic [TIME_W-1:0]   entry_time;
    logic                last_of_run;
    logic [CNT_W-1:0]    written_total;
    logic [CNT_W-1:0]    missed_total;
    logic [CNT_W-1:0]    read_total;
    logic [FILL_W-1:0]   fill_level;
  } result_t;

endpackage

`default_nettype wire

/* hdl/etrb_ram.sv */
// ----------------------------------------------------------------------------
// etrb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module etrb_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/etrb_out_reg.sv */
// ----------------------------------------------------------------------------
// etrb_out_reg
// result holding register between the sequencer and the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module etrb_out_reg
  import etrb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    ready_i,
  output logic         valid_o,
  output logic         free_o,
  output result_t      res_o
);

  logic    valid_d, valid_q;
  result_t res_q;

  // slot may be refilled in the cycle its result is taken
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* hdl/event_trace_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_core
// event trace recorder over a power-of-two ring held in a synchronous ram
// ----------------------------------------------------------------------------
// A record, reset or unused request gives one result. A read request that
// drains n entries first starts the first ram read, then delivers one entry
// per cycle through the registered read port of the entry ram; a read that
// finds nothing gives one result. The block works on one request at a time
// and takes the next one once the last result of the current one has been
// loaded, provided the output register is empty or its result is taken in
// that same cycle; a waiting result holds off the next request and a stalled
// output stretches the drain.
// The entry ram needs no clearing pass, as entries are read only after they
// have been written. Configuration writes are always taken and are meant
// for an idle block; a ring size write clears both pointers.
`default_nettype none
`include "event_trace_ring_buffer_core_defines.svh"

module event_trace_ring_buffer_core
  import etrb_pkg::*;
#(
  parameter int unsigned MAX_RING_LOG2 = 10,
  parameter int unsigned MAX_READ_RUN  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // event_kind[2:0], event_cpu[10:3], event_time[42:11], max_entries[49:43]
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  wire logic [CMD_W-1:0]      s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // entry_kind[2:0], entry_time[34:3], written_total[66:35],
  // missed_total[98:67], read_total[130:99], fill_level[141:131]
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  // status[2:0]
  output logic [STATUS_W-1:0]        m_axis_tuser,
  output logic                       m_axis_tlast,
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ADDR_W = MAX_RING_LOG2;
  localparam int unsigned DEPTH  = 1 << MAX_RING_LOG2;
  localparam int unsigned PTR_W  = MAX_RING_LOG2 + 1;
  localparam int unsigned RSL_W  = $clog2(MAX_RING_LOG2 + 1);
  localparam int unsigned RUN_W  = $clog2(MAX_READ_RUN + 1);
  localparam int unsigned CMP_W  = (PTR_W > MAXE_W) ? PTR_W : MAXE_W;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e             state_d, state_q;
  logic               trace_en_d, trace_en_q;
  logic [RSL_W-1:0]   rsl_d, rsl_q;
  logic [PTR_W-1:0]   rd_ptr_d, rd_ptr_q;
  logic [PTR_W-1:0]   wr_ptr_d, wr_ptr_q;
  logic [CPU_W-1:0]   cur_cpu_d, cur_cpu_q;
  logic [CNT_W-1:0]   written_d, written_q;
  logic [CNT_W-1:0]   missed_d, missed_q;
  logic [CNT_W-1:0]   read_cnt_d, read_cnt_q;
  logic [RUN_W-1:0]   run_left_d, run_left_q;

  // request fields
  logic [KIND_W-1:0]  in_kind;
  logic [CPU_W-1:0]   in_cpu;
  logic [TIME_W-1:0]  in_time;
  logic [MAXE_W-1:0]  in_maxe;
  cmd_e               in_cmd;
  logic               in_acc;
  logic               cfg_acc;

  // ring geometry
  logic [PTR_W-1:0]   ring_size;
  logic [PTR_W-1:0]   ring_mask;
  logic [PTR_W-1:0]   fill_q;
  logic               ring_full;
  logic [CMP_W-1:0]   maxe_clamped;
  logic [CMP_W-1:0]   fill_ext;
  logic [CMP_W-1:0]   run_len;
  logic [PTR_W-1:0]   wr_masked;
  logic [PTR_W-1:0]   rd_masked;

  // entry ram
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // output register
  result_t            res;
  result_t            res_out;
  logic               res_load;
  logic               res_room;

  assign in_kind = s_axis_tdata[KIND_W-1:0];
  assign in_cpu  = s_axis_tdata[KIND_W+CPU_W-1:KIND_W];
  assign in_time = s_axis_tdata[KIND_W+CPU_W+TIME_W-1:KIND_W+CPU_W];
  assign in_maxe = s_axis_tdata[KIND_W+CPU_W+TIME_W+MAXE_W-1:KIND_W+CPU_W+TIME_W];
  assign in_cmd  = cmd_e'(s_axis_tuser);

  // one request at a time, and only when its result has a place to go
  assign s_axis_tready = (state_q == S_IDLE) && res_room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;

  assign ring_size = PTR_W'(1) << rsl_q;
  assign ring_mask = ring_size - PTR_W'(1);
  assign fill_q    = wr_ptr_q - rd_ptr_q;
  assign ring_full = fill_q >= ring_size;

  // read run length: fill level limited by the clamped request limit
  assign maxe_clamped = (32'(in_maxe) > 32'(MAX_READ_RUN)) ? CMP_W'(MAX_READ_RUN)
                                                           : CMP_W'(in_maxe);
  assign fill_ext     = CMP_W'(fill_q);
  assign run_len      = (fill_ext > maxe_clamped) ? maxe_clamped : fill_ext;

  always_comb begin
    state_d    = state_q;
    trace_en_d = trace_en_q;
    rsl_d      = rsl_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    cur_cpu_d  = cur_cpu_q;
    written_d  = written_q;
    missed_d   = missed_q;
    read_cnt_d = read_cnt_q;
    run_left_d = run_left_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_load   = 1'b0;
    res        = '0;
    res.status = ST_IGNORED;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_load        = 1'b1;
          res.last_of_run = 1'b1;
          case (in_cmd)
            CMD_RECORD: begin
              if (trace_en_q && (in_kind == KIND_SWITCH_IN || in_kind == KIND_SWITCH_OUT ||
                                 in_cpu == cur_cpu_q)) begin
                if (ring_full) begin
                  missed_d   = missed_q + CNT_W'(1);
                  res.status = ST_DROPPED;
                end else begin
                  ram_we     = 1'b1;
                  wr_ptr_d   = wr_ptr_q + PTR_W'(1);
                  written_d  = written_q + CNT_W'(1);
                  res.status = ST_RECORDED;
                end
                // a switch-in moves the current cpu even when dropped
                if (in_kind == KIND_SWITCH_IN) begin
                  cur_cpu_d = in_cpu;
                end
              end
            end
            CMD_READ: begin
              if (run_len == '0) begin
                res.status = ST_EMPTY;
              end else begin
                // start the first entry read, results follow from the drain
                res_load   = 1'b0;
                ram_re     = 1'b1;
                run_left_d = RUN_W'(run_len);
                state_d    = S_DRAIN;
              end
            end
            CMD_RESET: begin
              if (trace_en_q) begin
                res.status = ST_REFUSED;
              end else begin
                rd_ptr_d   = '0;
                wr_ptr_d   = '0;
                written_d  = '0;
                missed_d   = '0;
                read_cnt_d = '0;
                res.status = ST_CLEARED;
              end
            end
            default: begin
              res.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_DRAIN: begin
        // read data of the current entry is held in the ram until consumed
        if (res_room) begin
          res_load        = 1'b1;
          res.status      = ST_ENTRY;
          res.entry_kind  = ram_rdata[ENTRY_W-1:TIME_W];
          res.entry_time  = ram_rdata[TIME_W-1:0];
          res.last_of_run = (run_left_q == RUN_W'(1));
          rd_ptr_d        = rd_ptr_q + PTR_W'(1);
          read_cnt_d      = read_cnt_q + CNT_W'(1);
          run_left_d      = run_left_q - RUN_W'(1);
          if (run_left_q == RUN_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TRACE_ENABLE: begin
          trace_en_d = cfg_data_i[0];
        end
        CFG_RING_SIZE: begin
          // sizes beyond the ram saturate to the full ram
          if (32'(cfg_data_i) > 32'(MAX_RING_LOG2)) begin
            rsl_d = RSL_W'(MAX_RING_LOG2);
          end else begin
            rsl_d = RSL_W'(cfg_data_i);
          end
          rd_ptr_d = '0;
          wr_ptr_d = '0;
        end
        default: begin
        end
      endcase
    end

    // counters and fill level as they stand after this result
    res.written_total = written_d;
    res.missed_total  = missed_d;
    res.read_total    = read_cnt_d;
    res.fill_level    = FILL_W'(wr_ptr_d - rd_ptr_d);
  end

  // ram addressing: write at the write pointer, read at the next read pointer
  assign wr_masked = wr_ptr_q & ring_mask;
  assign rd_masked = rd_ptr_d & ring_mask;
  assign ram_waddr = wr_masked[ADDR_W-1:0];
  assign ram_raddr = rd_masked[ADDR_W-1:0];
  assign ram_wdata = {in_kind, in_time};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      trace_en_q <= 1'b0;
      rsl_q      <= RSL_W'(MAX_RING_LOG2);
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cur_cpu_q  <= '0;
      written_q  <= '0;
      missed_q   <= '0;
      read_cnt_q <= '0;
      run_left_q <= '0;
    end else begin
      state_q    <= state_d;
      trace_en_q <= trace_en_d;
      rsl_q      <= rsl_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      cur_cpu_q  <= cur_cpu_d;
      written_q  <= written_d;
      missed_q   <= missed_d;
      read_cnt_q <= read_cnt_d;
      run_left_q <= run_left_d;
    end
  end

  etrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  etrb_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (res_room),
    .res_o   (res_out)
  );

  assign m_axis_tuser = res_out.status;
  assign m_axis_tlast = res_out.last_of_run;
  assign m_axis_tdata = {2'b00,
                         res_out.fill_level,
                         res_out.read_total,
                         res_out.missed_total,
                         res_out.written_total,
                         res_out.entry_time,
                         res_out.entry_kind};

  // ring never holds more entries than its size
  `ETRB_ASSERT(a_fill_in_range, fill_q <= ring_size, "fill level beyond ring size")
  // a drain always has entries left to deliver
  `ETRB_ASSERT(a_drain_nonzero, (state_q == S_DRAIN) |-> (run_left_q != '0), "empty drain")
  // the last result of a request returns the sequencer to idle
  `ETRB_ASSERT_NEXT(a_last_idles, res_load && res.last_of_run, state_q == S_IDLE,
                    "sequencer busy after last result")
  // ram writes and drain reads never overlap
  `ETRB_ASSERT(a_no_write_in_drain, ram_we |-> (state_q == S_IDLE && !ram_re),
               "entry write during drain")

endmodule

`default_nettype wire
